[hw/rtl/pse_pkg.sv]
// Shared constants for the polyline stroke expander.
package pse_pkg;

  localparam int STROKE_BITS  = 16;
  localparam int STROKE_SHIFT = 9;
  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [STROKE_BITS-1:0] STROKE_RESET = 16'd256;

  localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_STROKE = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_WAVE   = 2'd1;

  // Normalized tangent magnitudes sit in [2^30, 2^31)
  localparam int NORM_BITS = 31;
  localparam int MUL_BITS  = 32;
  localparam int PROD_BITS = 2 * MUL_BITS;
  localparam int CNT_BITS  = 5;

endpackage

[hw/rtl/pse_offset_unit.sv]
// Iterative offset unit: normalize, square, root and divide on one shared datapath.
module pse_offset_unit #(
  parameter int COORD_BITS = 24,
  parameter int FRAC_BITS  = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic signed [COORD_BITS:0]    tan_x,
  input  logic signed [COORD_BITS:0]    tan_y,
  input  logic                          wave,
  input  logic [pse_pkg::STROKE_BITS-1:0] stroke,
  output logic                          done,
  output logic signed [pse_pkg::STROKE_BITS+FRAC_BITS-8:0] off_x,
  output logic signed [pse_pkg::STROKE_BITS+FRAC_BITS-8:0] off_y
);
  import pse_pkg::*;

  localparam int TW    = COORD_BITS + 1;
  localparam int NW    = (TW > NORM_BITS) ? TW : NORM_BITS;
  localparam int SBITS = STROKE_BITS + FRAC_BITS;
  localparam int QB    = SBITS - 8;
  localparam int OW    = QB + 1;
  localparam int DENW  = MUL_BITS + STROKE_SHIFT;
  localparam int RW    = (DENW + QB > PROD_BITS) ? DENW + QB : PROD_BITS;

  typedef enum logic [3:0] {
    U_IDLE, U_NORM, U_SQX, U_SQY, U_SUM, U_SQRT,
    U_MULX, U_DIVX0, U_DIVX, U_MULY, U_DIVY0, U_DIVY, U_DONE
  } ustate_t;

  ustate_t              state_r;
  logic [NW-1:0]        ax_r, ay_r;
  logic                 tx_neg_r, ty_pos_r;
  logic [SBITS-1:0]     s_r;
  logic [PROD_BITS-1:0] prod_r, v_r, r_r, bit_r;
  logic [RW-1:0]        rem_r, dsh_r;
  logic [QB-1:0]        q_r, mag_x_r;
  logic [CNT_BITS-1:0]  cnt_r;
  logic signed [OW-1:0] off_x_r, off_y_r;

  logic [TW-1:0]        abs_x, abs_y;
  logic [NW-1:0]        m;
  logic [MUL_BITS-1:0]  mul_a, mul_b;
  logic [PROD_BITS-1:0] rb;
  logic [RW-1:0]        rem_nxt;
  logic                 qbit;
  logic [QB-1:0]        q_nxt;
  logic [SBITS:0]       wave_sum;
  logic [QB-1:0]        wave_mag;
  logic [MUL_BITS-1:0]  len;

  // Magnitudes of the tangent
  assign abs_x = tan_x[TW-1] ? TW'(-tan_x) : TW'(tan_x);
  assign abs_y = tan_y[TW-1] ? TW'(-tan_y) : TW'(tan_y);
  assign m     = (ax_r > ay_r) ? ax_r : ay_r;

  // Shared multiplier operand select
  always_comb begin
    mul_a = MUL_BITS'(ax_r[NORM_BITS-1:0]);
    mul_b = MUL_BITS'(ax_r[NORM_BITS-1:0]);
    case (state_r)
      U_SQY:   begin mul_a = MUL_BITS'(ay_r[NORM_BITS-1:0]); mul_b = mul_a; end
      U_MULX:  begin mul_a = MUL_BITS'(ay_r[NORM_BITS-1:0]); mul_b = MUL_BITS'(s_r); end
      U_MULY:  begin mul_a = MUL_BITS'(ax_r[NORM_BITS-1:0]); mul_b = MUL_BITS'(s_r); end
      default: ;
    endcase
  end

  // One restoring divide step and one root step
  assign rb      = r_r + bit_r;
  assign qbit    = (rem_r >= dsh_r);
  assign rem_nxt = qbit ? (rem_r - dsh_r) : rem_r;
  assign q_nxt   = {q_r[QB-2:0], qbit};
  assign len     = r_r[MUL_BITS-1:0];

  // Vertical offset for wave mode
  assign wave_sum = (SBITS+1)'(stroke) * (SBITS+1)'(1 << FRAC_BITS)
                    + (SBITS+1)'(1 << (STROKE_SHIFT-1));
  assign wave_mag = QB'(wave_sum >> STROKE_SHIFT);

  always_ff @(posedge clk) begin
    prod_r <= PROD_BITS'(mul_a) * PROD_BITS'(mul_b);
    if (!rst_n) begin
      state_r <= U_IDLE;
    end else begin
      unique case (state_r)
        U_IDLE: begin
          if (start) begin
            ax_r     <= NW'(abs_x);
            ay_r     <= NW'(abs_y);
            tx_neg_r <= tan_x[TW-1];
            ty_pos_r <= !tan_y[TW-1] && (tan_y != '0);
            s_r      <= SBITS'(stroke) << FRAC_BITS;
            if (wave) begin
              off_x_r <= '0;
              off_y_r <= OW'(wave_mag);
              state_r <= U_DONE;
            end else if (tan_x == '0 && tan_y == '0) begin
              off_x_r <= '0;
              off_y_r <= '0;
              state_r <= U_DONE;
            end else begin
              state_r <= U_NORM;
            end
          end
        end
        // Bring the larger magnitude into [2^30, 2^31), one bit a cycle
        U_NORM: begin
          if ((m >> (NORM_BITS-1)) == '0) begin
            ax_r <= ax_r << 1;
            ay_r <= ay_r << 1;
          end else if ((m >> NORM_BITS) != '0) begin
            ax_r <= ax_r >> 1;
            ay_r <= ay_r >> 1;
          end else begin
            state_r <= U_SQX;
          end
        end
        U_SQX: state_r <= U_SQY;
        U_SQY: begin
          v_r     <= prod_r;
          state_r <= U_SUM;
        end
        U_SUM: begin
          v_r     <= v_r + prod_r;
          r_r     <= '0;
          bit_r   <= PROD_BITS'(1) << (PROD_BITS-2);
          cnt_r   <= CNT_BITS'(PROD_BITS/2 - 1);
          state_r <= U_SQRT;
        end
        U_SQRT: begin
          if (v_r >= rb) begin
            v_r <= v_r - rb;
            r_r <= (r_r >> 1) + bit_r;
          end else begin
            r_r <= r_r >> 1;
          end
          bit_r <= bit_r >> 2;
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == '0) state_r <= U_MULX;
        end
        U_MULX: state_r <= U_DIVX0;
        U_MULY: state_r <= U_DIVY0;
        U_DIVX0, U_DIVY0: begin
          rem_r   <= RW'(prod_r) + (RW'(len) << (STROKE_SHIFT-1));
          dsh_r   <= RW'(len) << (STROKE_SHIFT + QB - 1);
          q_r     <= '0;
          cnt_r   <= CNT_BITS'(QB - 1);
          state_r <= (state_r == U_DIVX0) ? U_DIVX : U_DIVY;
        end
        U_DIVX, U_DIVY: begin
          rem_r <= rem_nxt;
          dsh_r <= dsh_r >> 1;
          q_r   <= q_nxt;
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == '0) begin
            if (state_r == U_DIVX) begin
              mag_x_r <= q_nxt;
              state_r <= U_MULY;
            end else begin
              off_x_r <= ty_pos_r ? -$signed(OW'(mag_x_r)) : $signed(OW'(mag_x_r));
              off_y_r <= tx_neg_r ? -$signed(OW'(q_nxt)) : $signed(OW'(q_nxt));
              state_r <= U_DONE;
            end
          end
        end
        U_DONE: state_r <= U_IDLE;
        default: state_r <= U_IDLE;
      endcase
    end
  end

  assign done  = (state_r == U_DONE);
  assign off_x = off_x_r;
  assign off_y = off_y_r;

  // Division runs only after a nonzero root
  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == U_DIVX0 |-> len != '0)
    else $error("zero divisor");
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == U_DONE |=> state_r == U_IDLE)
    else $error("done not single");
  a_sqrt_exit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == U_MULX |-> $past(state_r) == U_SQRT)
    else $error("multiply out of order");

endmodule

[hw/rtl/polyline_stroke_expander_core.sv]
// Top level of the polyline stroke expander: point history, job control and output beat.
//
// Usage:
//   Points enter on the in_ channel (in_valid / in_stall), one beat per point,
//   in_last_point set on the final point of a polyline. Each point yields a
//   pair of triangle-strip vertices on the out_ channel (out_valid /
//   out_stall), one beat per pair, one point late; the final point releases
//   two beats, a lone point one beat. The first point of a polyline yields
//   nothing at once.
//   The cfg_ channel writes stroke_width (index 0) and wave_mode (index 1);
//   cfg_ready is always high, other indexes are dropped.
//   Each pair's time from its start to out_valid is set by the shared offset
//   unit in normal mode (normalization shift loop, 32 root steps, two
//   restoring divides); wave mode and zero tangents go straight to done.
//   in_stall stays high while a point is being worked and its pairs are not
//   all taken. A stalled result holds in the output register.
//   Reset clears the point history, the output valid and loads stroke_width
//   256, wave_mode 0.
module polyline_stroke_expander_core #(
  parameter int COORD_BITS = 24,
  parameter int FRAC_BITS  = 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [COORD_BITS-1:0]         in_point_x,
  input  logic signed [COORD_BITS-1:0]         in_point_y,
  input  logic                                 in_last_point,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [COORD_BITS-1:0]         out_left_x,
  output logic signed [COORD_BITS-1:0]         out_left_y,
  output logic signed [COORD_BITS-1:0]         out_right_x,
  output logic signed [COORD_BITS-1:0]         out_right_y,
  output logic                                 out_last_pair,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [pse_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [pse_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
  import pse_pkg::*;

  localparam int TW = COORD_BITS + 1;
  localparam int QB = STROKE_BITS + FRAC_BITS - 8;
  localparam int OW = QB + 1;
  localparam int SW = ((COORD_BITS > OW) ? COORD_BITS : OW) + 2;
  localparam logic signed [SW-1:0] SAT_HI = SW'((64'sd1 <<< (COORD_BITS-1)) - 1);
  localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);

  typedef enum logic [1:0] {T_IDLE, T_CALC, T_OUT} tstate_t;

  tstate_t                      state_r;
  logic [STROKE_BITS-1:0]       stroke_r;
  logic                         wave_r;
  logic signed [COORD_BITS-1:0] prev_x_r, prev_y_r, prev2_x_r, prev2_y_r;
  logic [1:0]                   seen_r;
  logic signed [COORD_BITS-1:0] jx_r, jy_r, j2x_r, j2y_r;
  logic signed [TW-1:0]         tx_r, ty_r, t2x_r, t2y_r;
  logic                         jlast_r, has2_r, start_r;
  logic                         out_valid_r, out_last_r;
  logic signed [COORD_BITS-1:0] lx_r, ly_r, rx_r, ry_r;

  logic                         in_beat, out_beat, unit_done;
  logic signed [OW-1:0]         off_x, off_y;
  logic signed [COORD_BITS-1:0] base_x, base_y;
  logic signed [TW-1:0]         t1x, t1y, tpx, tpy;
  logic signed [SW-1:0]         slx, sly, srx, sry;

  assign in_beat   = in_valid && !in_stall;
  assign out_beat  = out_valid_r && !out_stall;
  assign in_stall  = (state_r != T_IDLE);
  assign cfg_ready = 1'b1;

  // Tangents: central difference, one-sided at the first and last points
  assign base_x = (seen_r == 2'd1) ? prev_x_r : prev2_x_r;
  assign base_y = (seen_r == 2'd1) ? prev_y_r : prev2_y_r;
  assign t1x = TW'(in_point_x) - TW'(base_x);
  assign t1y = TW'(in_point_y) - TW'(base_y);
  assign tpx = TW'(in_point_x) - TW'(prev_x_r);
  assign tpy = TW'(in_point_y) - TW'(prev_y_r);

  pse_offset_unit #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_off (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start_r),
    .tan_x (tx_r),
    .tan_y (ty_r),
    .wave  (wave_r),
    .stroke(stroke_r),
    .done  (unit_done),
    .off_x (off_x),
    .off_y (off_y)
  );

  // Vertex sums before saturation
  assign slx = SW'(jx_r) + SW'(off_x);
  assign sly = SW'(jy_r) + SW'(off_y);
  assign srx = SW'(jx_r) - SW'(off_x);
  assign sry = SW'(jy_r) - SW'(off_y);

  function automatic logic signed [COORD_BITS-1:0] clip(input logic signed [SW-1:0] v);
    if (v > SAT_HI) clip = COORD_BITS'(SAT_HI);
    else if (v < SAT_LO) clip = COORD_BITS'(SAT_LO);
    else clip = COORD_BITS'(v);
  endfunction

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stroke_r <= STROKE_RESET;
      wave_r   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_IDX_STROKE: stroke_r <= STROKE_BITS'(cfg_data);
        CFG_IDX_WAVE:   wave_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Sequencer, point history and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      seen_r      <= 2'd0;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      prev2_x_r   <= '0;
      prev2_y_r   <= '0;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
      has2_r      <= 1'b0;
    end else begin
      start_r <= 1'b0;
      unique case (state_r)
        T_IDLE: begin
          if (in_beat) begin
            if (seen_r == 2'd0 && !in_last_point) begin
              prev_x_r <= in_point_x;
              prev_y_r <= in_point_y;
              seen_r   <= 2'd1;
            end else if (seen_r == 2'd0) begin
              jx_r    <= in_point_x;
              jy_r    <= in_point_y;
              tx_r    <= '0;
              ty_r    <= '0;
              jlast_r <= 1'b1;
              has2_r  <= 1'b0;
              start_r <= 1'b1;
              state_r <= T_CALC;
            end else begin
              jx_r    <= prev_x_r;
              jy_r    <= prev_y_r;
              tx_r    <= t1x;
              ty_r    <= t1y;
              jlast_r <= 1'b0;
              has2_r  <= in_last_point;
              j2x_r   <= in_point_x;
              j2y_r   <= in_point_y;
              t2x_r   <= tpx;
              t2y_r   <= tpy;
              start_r <= 1'b1;
              state_r <= T_CALC;
              if (in_last_point) begin
                seen_r <= 2'd0;
              end else begin
                prev2_x_r <= prev_x_r;
                prev2_y_r <= prev_y_r;
                prev_x_r  <= in_point_x;
                prev_y_r  <= in_point_y;
                seen_r    <= 2'd2;
              end
            end
          end
        end
        T_CALC: begin
          if (unit_done) begin
            lx_r        <= clip(slx);
            ly_r        <= clip(sly);
            rx_r        <= clip(srx);
            ry_r        <= clip(sry);
            out_last_r  <= jlast_r;
            out_valid_r <= 1'b1;
            state_r     <= T_OUT;
          end
        end
        T_OUT: begin
          if (out_beat) begin
            out_valid_r <= 1'b0;
            if (has2_r) begin
              jx_r    <= j2x_r;
              jy_r    <= j2y_r;
              tx_r    <= t2x_r;
              ty_r    <= t2y_r;
              jlast_r <= 1'b1;
              has2_r  <= 1'b0;
              start_r <= 1'b1;
              state_r <= T_CALC;
            end else begin
              state_r <= T_IDLE;
            end
          end
        end
        default: state_r <= T_IDLE;
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_left_x    = lx_r;
  assign out_left_y    = ly_r;
  assign out_right_x   = rx_r;
  assign out_right_y   = ry_r;
  assign out_last_pair = out_last_r;

  a_done_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
    unit_done |-> state_r == T_CALC)
    else $error("offset result outside calc");
  a_seen_range: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r != 2'd3)
    else $error("point count overflow");
  a_out_from_unit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(unit_done))
    else $error("result without offset");
  a_second_pair_last: assert property (@(posedge clk) disable iff (!rst_n)
    has2_r && state_r != T_IDLE |-> !jlast_r)
    else $error("pending pair after final");

endmodule

[tb/sv/polyline_stroke_expander_core_tb.sv]
// Self-checking testbench for the polyline stroke expander core.
module polyline_stroke_expander_core_tb;
  import pse_pkg::*;

  localparam int CW = 24;
  localparam int FB = 8;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 250;

  // Register indexes that map to no register
  localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_SPARE_B = 2'd3;

  typedef struct {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic                 last;
  } point_t;

  typedef struct {
    logic signed [CW-1:0] lx;
    logic signed [CW-1:0] ly;
    logic signed [CW-1:0] rx;
    logic signed [CW-1:0] ry;
    logic                 last;
  } vpair_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic signed [CW-1:0] in_point_x;
  logic signed [CW-1:0] in_point_y;
  logic in_last_point;
  logic out_valid;
  logic out_stall;
  logic signed [CW-1:0] out_left_x;
  logic signed [CW-1:0] out_left_y;
  logic signed [CW-1:0] out_right_x;
  logic signed [CW-1:0] out_right_y;
  logic out_last_pair;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  polyline_stroke_expander_core #(.COORD_BITS(CW), .FRAC_BITS(FB)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_point_x(in_point_x), .in_point_y(in_point_y), .in_last_point(in_last_point),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_left_x(out_left_x), .out_left_y(out_left_y),
    .out_right_x(out_right_x), .out_right_y(out_right_y),
    .out_last_pair(out_last_pair),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow copy of the block's registers and point history
  logic [15:0] sh_stroke;
  logic        sh_wave;
  longint      hist_x, hist_y, hist2_x, hist2_y;
  int          held_points;

  point_t pending_points[$];
  vpair_t expected_pairs[$];
  int     errors;
  int     mismatches;
  bit     calm;
  int     idle_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic signed [CW-1:0] clamp_coord(longint v);
    longint hi, lo;
    hi = (longint'(1) <<< (CW - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[CW-1:0];
  endfunction

  // Offset a point along the stroke normal (or vertically in wave mode)
  function automatic vpair_t stroke_pair(longint px, longint py, longint tx, longint ty,
                                         logic last);
    longint unsigned s, ax, ay, m, len, den, mx, my;
    longint offx, offy;
    vpair_t p;
    s = longint'(sh_stroke) << FB;
    offx = 0;
    offy = 0;
    if (sh_wave) begin
      offy = longint'((s + 256) >> STROKE_SHIFT);
    end else begin
      ax = (tx < 0) ? -tx : tx;
      ay = (ty < 0) ? -ty : ty;
      m = (ax > ay) ? ax : ay;
      if (m != 0) begin
        while (m < (64'd1 << 30)) begin
          ax = ax << 1; ay = ay << 1; m = m << 1;
        end
        while (m >= (64'd1 << 31)) begin
          ax = ax >> 1; ay = ay >> 1; m = m >> 1;
        end
        len = int_sqrt(ax * ax + ay * ay);
        den = len << STROKE_SHIFT;
        mx = (ay * s + den / 2) / den;
        my = (ax * s + den / 2) / den;
        offx = (ty > 0) ? -longint'(mx) : longint'(mx);
        offy = (tx < 0) ? -longint'(my) : longint'(my);
      end
    end
    p.lx = clamp_coord(px + offx);
    p.ly = clamp_coord(py + offy);
    p.rx = clamp_coord(px - offx);
    p.ry = clamp_coord(py - offy);
    p.last = last;
    return p;
  endfunction

  // Advance the point history and queue the pairs this point releases
  task automatic predict_point(point_t pt);
    longint px, py;
    px = longint'(pt.x);
    py = longint'(pt.y);
    if (held_points == 0) begin
      if (pt.last) begin
        expected_pairs.push_back(stroke_pair(px, py, 0, 0, 1'b1));
      end else begin
        hist_x = px; hist_y = py;
        held_points = 1;
      end
    end else begin
      if (held_points == 1)
        expected_pairs.push_back(stroke_pair(hist_x, hist_y, px - hist_x, py - hist_y, 1'b0));
      else
        expected_pairs.push_back(stroke_pair(hist_x, hist_y, px - hist2_x, py - hist2_y,
                                             1'b0));
      if (pt.last) begin
        expected_pairs.push_back(stroke_pair(px, py, px - hist_x, py - hist_y, 1'b1));
        held_points = 0;
      end else begin
        hist2_x = hist_x; hist2_y = hist_y;
        hist_x = px; hist_y = py;
        held_points = 2;
      end
    end
  endtask

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Input driver: present queued points, hold while stalled
  int in_gap;
  point_t cur_point;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_valid && !in_stall) predict_point(cur_point);
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap = in_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_points.size() > 0) begin
          cur_point = pending_points.pop_front();
          in_point_x <= cur_point.x;
          in_point_y <= cur_point.y;
          in_last_point <= cur_point.last;
          in_valid <= 1'b1;
          in_gap = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: random stall, compare each beat with the oldest expectation
  int out_gap;
  always @(posedge clk) begin
    vpair_t e;
    if (!rst_n) begin
      out_stall <= 1'b0;
      out_gap = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_pairs.size() == 0) begin
          errors++;
          if (mismatches < 10)
            $display("unexpected beat: L(%0d,%0d) R(%0d,%0d) last=%0b",
                     out_left_x, out_left_y, out_right_x, out_right_y, out_last_pair);
          mismatches++;
        end else begin
          e = expected_pairs.pop_front();
          if (e.lx !== out_left_x || e.ly !== out_left_y || e.rx !== out_right_x ||
              e.ry !== out_right_y || e.last !== out_last_pair) begin
            errors++;
            if (mismatches < 10)
              $display("mismatch: exp L(%0d,%0d) R(%0d,%0d) last=%0b got L(%0d,%0d) R(%0d,%0d) last=%0b",
                       e.lx, e.ly, e.rx, e.ry, e.last,
                       out_left_x, out_left_y, out_right_x, out_right_y, out_last_pair);
            mismatches++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap = out_gap - 1;
        out_stall <= 1'b1;
      end else begin
        out_gap = pick_gap();
        out_stall <= (out_gap > 0);
        if (out_gap > 0) out_gap = out_gap - 1;
      end
    end
  end

  // Watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] d);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_IDX_STROKE) sh_stroke = d;
    else if (idx == CFG_IDX_WAVE) sh_wave = d[0];
  endtask

  task automatic add_point(logic [CW-1:0] x, logic [CW-1:0] y, logic last);
    point_t p;
    p.x = x; p.y = y; p.last = last;
    pending_points.push_back(p);
  endtask

  task automatic wait_drained();
    while (pending_points.size() > 0 || in_valid || expected_pairs.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [CW-1:0] extreme_coord();
    case ($urandom_range(0, 3))
      0: return {1'b0, {(CW-1){1'b1}}};
      1: return {1'b1, {(CW-1){1'b0}}};
      2: return '0;
      default: return '1;
    endcase
  endfunction

  // Mostly well-formed polylines with coherent steps, some wild jumps
  task automatic add_random_polylines(int count);
    int n, len, k, step;
    logic [CW-1:0] bx, by;
    n = 0;
    while (n < count) begin
      len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 8);
      bx = CW'($urandom);
      by = CW'($urandom);
      step = 1 << $urandom_range(0, 16);
      for (k = 0; k < len; k++) begin
        case ($urandom_range(0, 9))
          0: begin bx = CW'($urandom); by = CW'($urandom); end
          1: begin bx = extreme_coord(); by = extreme_coord(); end
          2: ;
          default: begin
            bx = bx + CW'($urandom_range(0, 2 * step)) - CW'(step);
            by = by + CW'($urandom_range(0, 2 * step)) - CW'(step);
          end
        endcase
        add_point(bx, by, (k == len - 1) || (n + k + 1 >= count));
        if (n + k + 1 >= count) k = len;
      end
      n = n + len;
    end
  endtask

  initial begin
    logic [15:0] sw;
    int ph;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_point_x = '0;
    in_point_y = '0;
    in_last_point = 1'b0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    errors = 0;
    mismatches = 0;
    calm = 1'b0;
    idle_cycles = 0;
    sh_stroke = STROKE_RESET;
    sh_wave = 1'b0;
    hist_x = 0; hist_y = 0; hist2_x = 0; hist2_y = 0;
    held_points = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: lone points, zero tangent, extremes, saturation, plain segments
    add_point(24'h000000, 24'h000000, 1'b1);
    add_point(24'h7FFFFF, 24'h800000, 1'b1);
    add_point(24'h001000, 24'h002000, 1'b0);
    add_point(24'h001000, 24'h002000, 1'b1);
    add_point(24'h7FFFFF, 24'h7FFFFF, 1'b0);
    add_point(24'h800000, 24'h800000, 1'b0);
    add_point(24'h7FFFFF, 24'h800000, 1'b1);
    add_point(24'h000100, 24'h000000, 1'b0);
    add_point(24'h000200, 24'h000000, 1'b0);
    add_point(24'h000200, 24'h000100, 1'b0);
    add_point(24'h000000, 24'h000100, 1'b1);
    add_point(24'h7FFFF0, 24'h000000, 1'b0);
    add_point(24'h7FFFF0, 24'h000400, 1'b1);
    wait_drained();

    write_reg(CFG_IDX_STROKE, 16'hFFFF);
    write_reg(CFG_IDX_WAVE, 16'h0000);
    write_reg(CFG_IDX_SPARE_A, 16'h0000);
    write_reg(CFG_IDX_SPARE_B, 16'h1234);
    add_point(24'h800010, 24'h7FFFF0, 1'b0);
    add_point(24'h800010, 24'h000000, 1'b0);
    add_point(24'h000000, 24'h000000, 1'b1);
    add_point(24'h7FFFFF, 24'h7FFFFF, 1'b1);
    wait_drained();

    write_reg(CFG_IDX_WAVE, 16'hFFFF);
    add_point(24'h7FFFFF, 24'h7FFFFF, 1'b1);
    add_point(24'h800000, 24'h800000, 1'b0);
    add_point(24'h000000, 24'h000000, 1'b1);
    wait_drained();

    // Random phases over a spread of register settings
    for (ph = 0; ph < 7; ph++) begin
      case (ph)
        0: sw = 16'd0;
        1: sw = 16'hFFFF;
        2: sw = STROKE_RESET;
        default: sw = 16'($urandom);
      endcase
      write_reg(CFG_IDX_STROKE, sw);
      write_reg(CFG_IDX_WAVE, (ph == 3) ? 16'h0001 : 16'({$urandom} & 16'hFFFE));
      calm = (ph == 4);
      add_random_polylines(90);
      wait_drained();
    end

    if (errors == 0 && expected_pairs.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
